### design/two_key_sorted_priority_queue_defines.svh
// Assertion macros for the two-key sorted priority queue.
// Used by the top level only; no dependencies.
`ifndef TWO_KEY_SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define TWO_KEY_SORTED_PRIORITY_QUEUE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TKPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define TKPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define TKPQ_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define TKPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### design/tkpq_pkg.sv
// Shared types and constants for the two-key sorted priority queue.
// No dependencies.
package tkpq_pkg;
	localparam int unsigned FIELD_W       = 16;
	localparam int unsigned OCC_W         = 8;
	localparam int unsigned DEPTH_DEFAULT = 128;
	localparam int unsigned KEY_W_DEFAULT = 16;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_REMOVED  = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef struct packed {
		logic ins;
		logic rem;
	} cell_cmd_t;
endpackage

### design/tkpq_req_if.sv
// Request channel of the priority queue: valid/ready and one input item.
// Depends on tkpq_pkg.
interface tkpq_req_if import tkpq_pkg::*; ();
	logic               valid;
	logic               ready;
	op_t                operation;
	logic [FIELD_W-1:0] entry_tag;
	logic [FIELD_W-1:0] entry_priority;
	logic [FIELD_W-1:0] entry_treatment;

	modport source(output valid, operation, entry_tag, entry_priority, entry_treatment,
		input ready);
	modport sink(input valid, operation, entry_tag, entry_priority, entry_treatment,
		output ready);
endinterface

### design/tkpq_rsp_if.sv
// Response channel of the priority queue: valid/ready and one result item.
// Depends on tkpq_pkg.
interface tkpq_rsp_if import tkpq_pkg::*; ();
	logic               valid;
	logic               ready;
	status_t            status;
	logic [FIELD_W-1:0] out_tag;
	logic [FIELD_W-1:0] out_priority;
	logic [FIELD_W-1:0] out_treatment;
	logic [OCC_W-1:0]   occupancy;

	modport source(output valid, status, out_tag, out_priority, out_treatment, occupancy,
		input ready);
	modport sink(input valid, status, out_tag, out_priority, out_treatment, occupancy,
		output ready);
endinterface

### design/two_key_sorted_priority_queue.sv
// Two-key sorted priority queue: a chain of QUEUE_DEPTH cells, head in cell 0.
// The result is registered in the cycle after the item is accepted.
// One item per cycle while rsp is ready; every cell compares and shifts together.
// Reset clears the cell valid flags, the entry count and the response valid flag.
// Depends on tkpq_pkg, tkpq_req_if, tkpq_rsp_if, tkpq_cell and the defines header.
`include "two_key_sorted_priority_queue_defines.svh"
module two_key_sorted_priority_queue import tkpq_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = DEPTH_DEFAULT,
	parameter int unsigned KEY_WIDTH   = KEY_W_DEFAULT
) (
	input logic       clk,
	input logic       arst_n,
	tkpq_req_if.sink  req,
	tkpq_rsp_if.source rsp
);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     count_d;
	logic                 accept;
	logic                 full;
	logic                 empty;
	cell_cmd_t            cmd;
	logic [KEY_WIDTH-1:0] new_prio;
	logic [KEY_WIDTH-1:0] new_treat;
	logic                 head_swapped;

	logic                 c_take  [QUEUE_DEPTH];
	logic                 c_valid [QUEUE_DEPTH];
	logic [KEY_WIDTH-1:0] c_prio  [QUEUE_DEPTH];
	logic [KEY_WIDTH-1:0] c_treat [QUEUE_DEPTH];
	logic [FIELD_W-1:0]   c_tag   [QUEUE_DEPTH];

	logic                 rsp_valid_q;
	status_t              status_q;
	logic [FIELD_W-1:0]   tag_q;
	logic [FIELD_W-1:0]   prio_q;
	logic [FIELD_W-1:0]   treat_q;
	logic [OCC_W-1:0]     occ_q;
	status_t              status_d;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);
	assign new_prio  = KEY_WIDTH'(req.entry_priority);
	assign new_treat = KEY_WIDTH'(req.entry_treatment);

	assign cmd.ins = accept && (req.operation == OP_INSERT) && !full;
	assign cmd.rem = accept && (req.operation == OP_REMOVE) && !empty;

	genvar i;
	generate
		for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
			logic                 l_take;
			logic                 l_valid;
			logic [KEY_WIDTH-1:0] l_prio;
			logic [KEY_WIDTH-1:0] l_treat;
			logic [FIELD_W-1:0]   l_tag;
			logic                 r_valid;
			logic [KEY_WIDTH-1:0] r_prio;
			logic [KEY_WIDTH-1:0] r_treat;
			logic [FIELD_W-1:0]   r_tag;

			if (i == 0) begin : g_head
				assign l_take  = 1'b0;
				assign l_valid = 1'b0;
				assign l_prio  = new_prio;
				assign l_treat = new_treat;
				assign l_tag   = req.entry_tag;
			end else begin : g_mid
				assign l_take  = c_take[i-1];
				assign l_valid = c_valid[i-1];
				assign l_prio  = c_prio[i-1];
				assign l_treat = c_treat[i-1];
				assign l_tag   = c_tag[i-1];
			end

			if (i == QUEUE_DEPTH - 1) begin : g_tail
				assign r_valid = 1'b0;
				assign r_prio  = c_prio[i];
				assign r_treat = c_treat[i];
				assign r_tag   = c_tag[i];
			end else begin : g_body
				assign r_valid = c_valid[i+1];
				assign r_prio  = c_prio[i+1];
				assign r_treat = c_treat[i+1];
				assign r_tag   = c_tag[i+1];
			end

			tkpq_cell #(
				.KEY_WIDTH(KEY_WIDTH)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.cmd        (cmd),
				.new_prio   (new_prio),
				.new_treat  (new_treat),
				.new_tag    (req.entry_tag),
				.left_take  (l_take),
				.left_valid (l_valid),
				.left_prio  (l_prio),
				.left_treat (l_treat),
				.left_tag   (l_tag),
				.right_valid(r_valid),
				.right_prio (r_prio),
				.right_treat(r_treat),
				.right_tag  (r_tag),
				.take       (c_take[i]),
				.valid      (c_valid[i]),
				.prio       (c_prio[i]),
				.treat      (c_treat[i]),
				.tag        (c_tag[i])
			);
		end
	endgenerate

	always_comb begin
		count_d = count_q;
		if (cmd.ins) begin
			count_d = count_q + CNT_W'(1);
		end else if (cmd.rem) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	always_comb begin
		case (req.operation)
			OP_INSERT: status_d = full ? ST_FULL : ST_INSERTED;
			OP_REMOVE: status_d = empty ? ST_EMPTY : ST_REMOVED;
			default:   status_d = ST_EMPTY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			occ_q    <= OCC_W'(count_d);
			if (cmd.rem) begin
				tag_q   <= c_tag[0];
				prio_q  <= FIELD_W'(c_prio[0]);
				treat_q <= FIELD_W'(c_treat[0]);
			end else begin
				tag_q   <= '0;
				prio_q  <= '0;
				treat_q <= '0;
			end
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = status_q;
	assign rsp.out_tag       = tag_q;
	assign rsp.out_priority  = prio_q;
	assign rsp.out_treatment = treat_q;
	assign rsp.occupancy     = occ_q;

	assign head_swapped = (c_prio[1] < c_prio[0]) ||
		((c_prio[1] == c_prio[0]) && (c_treat[1] < c_treat[0]));

	`TKPQ_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(QUEUE_DEPTH))
	`TKPQ_ASSERT_NOW(a_head_valid, clk, arst_n, 1'b1, c_valid[0] == (count_q != '0))
	`TKPQ_ASSERT_NEXT(a_insert_count, clk, arst_n, cmd.ins, count_q == $past(count_q) + CNT_W'(1))
	`TKPQ_ASSERT_NOW(a_head_order, clk, arst_n, c_valid[1], !head_swapped)
endmodule

### design/tkpq_cell.sv
// One slot of the sorted chain: holds an entry, compares it with the new key,
// and loads the new or left entry on insert, right on remove. Uses tkpq_pkg.
module tkpq_cell import tkpq_pkg::*; #(
	parameter int unsigned KEY_WIDTH = KEY_W_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cell_cmd_t            cmd,
	input  logic [KEY_WIDTH-1:0] new_prio,
	input  logic [KEY_WIDTH-1:0] new_treat,
	input  logic [FIELD_W-1:0]   new_tag,
	input  logic                 left_take,
	input  logic                 left_valid,
	input  logic [KEY_WIDTH-1:0] left_prio,
	input  logic [KEY_WIDTH-1:0] left_treat,
	input  logic [FIELD_W-1:0]   left_tag,
	input  logic                 right_valid,
	input  logic [KEY_WIDTH-1:0] right_prio,
	input  logic [KEY_WIDTH-1:0] right_treat,
	input  logic [FIELD_W-1:0]   right_tag,
	output logic                 take,
	output logic                 valid,
	output logic [KEY_WIDTH-1:0] prio,
	output logic [KEY_WIDTH-1:0] treat,
	output logic [FIELD_W-1:0]   tag
);
	logic                 valid_q;
	logic [KEY_WIDTH-1:0] prio_q;
	logic [KEY_WIDTH-1:0] treat_q;
	logic [FIELD_W-1:0]   tag_q;

	// new entry goes here or further left
	assign take = !valid_q || (new_prio < prio_q) ||
		((new_prio == prio_q) && (new_treat < treat_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.rem) begin
			valid_q <= right_valid;
		end else if (cmd.ins && take) begin
			valid_q <= left_take ? left_valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rem) begin
			prio_q  <= right_prio;
			treat_q <= right_treat;
			tag_q   <= right_tag;
		end else if (cmd.ins && take) begin
			if (left_take) begin
				prio_q  <= left_prio;
				treat_q <= left_treat;
				tag_q   <= left_tag;
			end else begin
				prio_q  <= new_prio;
				treat_q <= new_treat;
				tag_q   <= new_tag;
			end
		end
	end

	assign valid = valid_q;
	assign prio  = prio_q;
	assign treat = treat_q;
	assign tag   = tag_q;
endmodule
